@@ rtl/bdi_pkg.sv @@
// shared types, constants and helpers for the backward difference interpolator
package bdi_pkg;

    localparam int MAX_POINTS  = 16;
    localparam int CNT_W       = $clog2(MAX_POINTS + 2);
    localparam int IDX_W       = $clog2(MAX_POINTS);
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // divider sizes: dividend magnitude, divisor magnitude
    localparam int DVD_W = 49;
    localparam int DVS_W = 33;
    localparam int DCNT_W = $clog2(DVD_W + 1);

    typedef enum logic [2:0] {
        ST_OK       = 3'd0,
        ST_TOO_FEW  = 3'd1,
        ST_ZERO_H   = 3'd2,
        ST_TOO_MANY = 3'd3,
        ST_SAT      = 3'd4
    } status_t;

    typedef enum logic {
        KIND_LOAD = 1'b0,
        KIND_EVAL = 1'b1
    } kind_t;

    typedef struct packed {
        logic signed [31:0] x_value;
        logic signed [31:0] y_value;
        logic signed [31:0] query_point;
        logic               last;
    } in_item_t;

    typedef struct packed {
        logic signed [31:0] interpolated;
        status_t            status;
    } out_item_t;

    typedef struct packed {
        in_item_t item;
        kind_t    kind;
    } q_item_t;

    typedef struct packed {
        logic               start;
        logic               neg;
        logic [DVD_W-1:0]   dividend;
        logic [DVS_W-1:0]   divisor;
    } div_req_t;

    typedef struct packed {
        logic               done;
        logic               sat;
        logic signed [31:0] value;
    } div_rsp_t;

    localparam logic signed [31:0] Q_MAX = 32'sh7fffffff;
    localparam logic signed [31:0] Q_MIN = 32'sh80000000;

    function automatic logic sat_hit(input logic signed [50:0] v);
        return (v > 51'(Q_MAX)) || (v < 51'(Q_MIN));
    endfunction

    function automatic logic signed [31:0] sat_val(input logic signed [50:0] v);
        logic signed [31:0] r;
        if (v > 51'(Q_MAX))
            r = Q_MAX;
        else if (v < 51'(Q_MIN))
            r = Q_MIN;
        else
            r = v[31:0];
        return r;
    endfunction

endpackage

@@ rtl/bdi_front.sv @@
// front end: accepts points, tags the evaluating one and queues them
module bdi_front (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_ready,
    input  bdi_pkg::in_item_t in_data,
    output logic             q_valid,
    input  logic             q_ready,
    output bdi_pkg::q_item_t q_data
);
    import bdi_pkg::*;

    q_item_t             mem_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0]   cnt_reg, cnt_next;
    logic                push, pop;
    q_item_t             entry;

    assign in_ready = (cnt_reg != QCNT_W'(QUEUE_DEPTH));
    assign q_valid  = (cnt_reg != '0);
    assign q_data   = mem_reg[rd_ptr_reg];
    assign push     = in_valid && in_ready;
    assign pop      = q_valid && q_ready;

    always_comb
    begin
        entry.item = in_data;
        entry.kind = in_data.last ? KIND_EVAL : KIND_LOAD;
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        cnt_next = cnt_reg;
        if (push && !pop)
            cnt_next = cnt_reg + 1'b1;
        else if (pop && !push)
            cnt_next = cnt_reg - 1'b1;
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wr_ptr_reg] <= entry;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= QCNT_W'(QUEUE_DEPTH))
        else $error("queue count beyond depth");

    a_full_no_push: assert property (@(posedge clk) disable iff (!rst_n)
        (cnt_reg == QCNT_W'(QUEUE_DEPTH)) && !pop |=> cnt_reg == QCNT_W'(QUEUE_DEPTH))
        else $error("queue lost an entry while full");

    a_ptr_gap: assert property (@(posedge clk) disable iff (!rst_n)
        (cnt_reg == '0) |-> (wr_ptr_reg == rd_ptr_reg))
        else $error("empty queue with pointers apart");

endmodule

@@ rtl/bdi_div.sv @@
// bit-serial restoring divider on magnitudes, signed and saturated result
module bdi_div (
    input  logic              clk,
    input  logic              rst_n,
    input  bdi_pkg::div_req_t req,
    output bdi_pkg::div_rsp_t rsp
);
    import bdi_pkg::*;

    logic [DVD_W-1:0]  dq_reg;
    logic [DVS_W-1:0]  rem_reg;
    logic [DVS_W-1:0]  dvs_reg;
    logic              neg_reg;
    logic              busy_reg;
    logic              done_reg;
    logic [DCNT_W-1:0] cnt_reg;
    logic [DVS_W:0]    rem_sh;
    logic [DVS_W:0]    trial;
    logic              fits;

    assign rem_sh = {rem_reg, dq_reg[DVD_W-1]};
    assign trial  = rem_sh - {1'b0, dvs_reg};
    assign fits   = !trial[DVS_W];

    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            dq_reg  <= req.dividend;
            rem_reg <= '0;
            dvs_reg <= req.divisor;
            neg_reg <= req.neg;
        end
        else if (busy_reg)
        begin
            rem_reg <= fits ? trial[DVS_W-1:0] : rem_sh[DVS_W-1:0];
            dq_reg  <= {dq_reg[DVD_W-2:0], fits};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (req.start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= DCNT_W'(DVD_W);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == DCNT_W'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_comb
    begin
        rsp.done = done_reg;
        if (!neg_reg)
        begin
            rsp.sat   = |dq_reg[DVD_W-1:31];
            rsp.value = rsp.sat ? Q_MAX : dq_reg[31:0];
        end
        else
        begin
            rsp.sat   = (|dq_reg[DVD_W-1:32]) || (dq_reg[31] && |dq_reg[30:0]);
            rsp.value = rsp.sat ? Q_MIN : -dq_reg[31:0];
        end
    end

    a_no_restart: assert property (@(posedge clk) disable iff (!rst_n)
        req.start |-> !busy_reg)
        else $error("divider started while busy");

    a_done_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> $past(busy_reg))
        else $error("divider done without a run");

    a_nonzero_divisor: assert property (@(posedge clk) disable iff (!rst_n)
        req.start |-> req.divisor != '0)
        else $error("divide by zero requested");

endmodule

@@ rtl/bdi_back.sv @@
// back end: difference table update and newton series evaluation
module bdi_back (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              q_valid,
    output logic              q_ready,
    input  bdi_pkg::q_item_t  q_data,
    output logic              out_valid,
    input  logic              out_ready,
    output bdi_pkg::out_item_t out_data,
    output bdi_pkg::div_req_t div_req,
    input  bdi_pkg::div_rsp_t div_rsp
);
    import bdi_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE, S_UPD, S_CHECK, S_U_WAIT, S_P_MUL, S_P_DIV,
        S_P_WAIT, S_T_MUL, S_ACC, S_FIN, S_DONE
    } state_t;

    state_t                   state_reg;
    q_item_t                  item_reg;
    logic signed [31:0]       first_x_reg, second_x_reg, last_x_reg;
    logic signed [31:0]       diff_reg [MAX_POINTS];
    logic [CNT_W-1:0]         count_reg;
    logic                     ovf_reg;
    logic [CNT_W-1:0]         k_reg;
    logic [CNT_W-1:0]         i_reg;
    logic signed [31:0]       cur_reg, u_reg, p_reg, s_reg;
    logic                     sat_reg;
    logic signed [65:0]       prod_reg;
    out_item_t                res_reg;
    out_item_t                out_reg;
    logic                     out_valid_reg;

    logic [IDX_W-1:0]         rd_idx;
    logic signed [31:0]       rd_data;
    logic signed [50:0]       cur_dif;
    logic signed [32:0]       dq, hq;
    logic signed [33:0]       v;
    logic [65:0]              prod_mag;
    logic signed [49:0]       term;
    logic signed [50:0]       sum;
    logic [CNT_W-1:0]         i_inc;
    logic                     out_load;

    assign q_ready   = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;
    assign out_load  = (state_reg == S_DONE) && (!out_valid_reg || out_ready);

    always_comb
    begin
        rd_idx   = (state_reg == S_UPD) ? k_reg[IDX_W-1:0] : i_reg[IDX_W-1:0];
        rd_data  = diff_reg[rd_idx];
        cur_dif  = 51'(cur_reg) - 51'(rd_data);
        dq       = 33'(item_reg.item.query_point) - 33'(last_x_reg);
        hq       = 33'(second_x_reg) - 33'(first_x_reg);
        v        = 34'(u_reg) + $signed({1'b0, 33'(i_reg - 1'b1) << 16});
        prod_mag = prod_reg[65] ? 66'(-prod_reg) : 66'(prod_reg);
        term     = prod_reg[65] ? -$signed({1'b0, prod_mag[64:16]})
                                :  $signed({1'b0, prod_mag[64:16]});
        sum      = 51'(s_reg) + 51'(term);
        i_inc    = i_reg + 1'b1;

        div_req.start    = 1'b0;
        div_req.neg      = 1'b0;
        div_req.dividend = '0;
        div_req.divisor  = '0;
        if (state_reg == S_CHECK)
        begin
            div_req.neg      = dq[32] ^ hq[32];
            div_req.dividend = {(dq[32] ? 33'(-dq) : 33'(dq)), 16'd0};
            div_req.divisor  = hq[32] ? 33'(-hq) : 33'(hq);
            div_req.start    = (count_reg <= CNT_W'(MAX_POINTS))
                            && (count_reg >= CNT_W'(2)) && (hq != '0);
        end
        else if (state_reg == S_P_DIV)
        begin
            div_req.start    = 1'b1;
            div_req.neg      = prod_reg[65];
            div_req.dividend = prod_mag[64:16];
            div_req.divisor  = DVS_W'(i_reg);
        end
    end

    // difference table: no reset, entries are written before use in a sequence
    always_ff @(posedge clk)
    begin
        if (state_reg == S_UPD)
        begin
            if (k_reg < count_reg)
                diff_reg[rd_idx] <= cur_reg;
            else
                diff_reg[count_reg[IDX_W-1:0]] <= cur_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        case (state_reg)
            S_IDLE:
                if (q_valid)
                    item_reg <= q_data;
            S_P_MUL:
                prod_reg <= 66'(p_reg) * 66'(v);
            S_T_MUL:
                prod_reg <= 66'(p_reg) * 66'(rd_data);
            default:
                ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            first_x_reg   <= '0;
            second_x_reg  <= '0;
            last_x_reg    <= '0;
            count_reg     <= '0;
            ovf_reg       <= 1'b0;
            k_reg         <= '0;
            i_reg         <= '0;
            cur_reg       <= '0;
            u_reg         <= '0;
            p_reg         <= '0;
            s_reg         <= '0;
            sat_reg       <= 1'b0;
            res_reg       <= '0;
            out_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (out_valid_reg && out_ready && !out_load)
                out_valid_reg <= 1'b0;
            case (state_reg)
                S_IDLE:
                    if (q_valid)
                    begin
                        if (count_reg < CNT_W'(MAX_POINTS))
                        begin
                            if (count_reg == '0)
                                first_x_reg <= q_data.item.x_value;
                            if (count_reg == CNT_W'(1))
                                second_x_reg <= q_data.item.x_value;
                            last_x_reg <= q_data.item.x_value;
                            cur_reg    <= q_data.item.y_value;
                            k_reg      <= '0;
                            state_reg  <= S_UPD;
                        end
                        else
                        begin
                            count_reg <= CNT_W'(MAX_POINTS + 1);
                            state_reg <= (q_data.kind == KIND_EVAL) ? S_CHECK : S_IDLE;
                        end
                    end
                S_UPD:
                    if (k_reg < count_reg)
                    begin
                        cur_reg <= sat_val(cur_dif);
                        ovf_reg <= ovf_reg | sat_hit(cur_dif);
                        k_reg   <= k_reg + 1'b1;
                    end
                    else
                    begin
                        count_reg <= count_reg + 1'b1;
                        state_reg <= (item_reg.kind == KIND_EVAL) ? S_CHECK : S_IDLE;
                    end
                S_CHECK:
                begin
                    res_reg.interpolated <= '0;
                    p_reg   <= 32'sd65536;
                    s_reg   <= diff_reg[0];
                    i_reg   <= CNT_W'(1);
                    sat_reg <= ovf_reg;
                    if (count_reg > CNT_W'(MAX_POINTS))
                    begin
                        res_reg.status <= ST_TOO_MANY;
                        state_reg <= S_DONE;
                    end
                    else if (count_reg < CNT_W'(2))
                    begin
                        res_reg.status <= ST_TOO_FEW;
                        state_reg <= S_DONE;
                    end
                    else if (hq == '0)
                    begin
                        res_reg.status <= ST_ZERO_H;
                        state_reg <= S_DONE;
                    end
                    else
                        state_reg <= S_U_WAIT;
                end
                S_U_WAIT:
                    if (div_rsp.done)
                    begin
                        u_reg   <= div_rsp.value;
                        sat_reg <= sat_reg | div_rsp.sat;
                        state_reg <= (i_reg < count_reg) ? S_P_MUL : S_FIN;
                    end
                S_P_MUL:
                    state_reg <= S_P_DIV;
                S_P_DIV:
                    state_reg <= S_P_WAIT;
                S_P_WAIT:
                    if (div_rsp.done)
                    begin
                        p_reg   <= div_rsp.value;
                        sat_reg <= sat_reg | div_rsp.sat;
                        state_reg <= S_T_MUL;
                    end
                S_T_MUL:
                    state_reg <= S_ACC;
                S_ACC:
                begin
                    s_reg   <= sat_val(sum);
                    sat_reg <= sat_reg | sat_hit(sum);
                    i_reg   <= i_inc;
                    state_reg <= (i_inc < count_reg) ? S_P_MUL : S_FIN;
                end
                S_FIN:
                begin
                    res_reg.interpolated <= s_reg;
                    res_reg.status <= sat_reg ? ST_SAT : ST_OK;
                    state_reg <= S_DONE;
                end
                S_DONE:
                    if (out_load)
                    begin
                        out_reg       <= res_reg;
                        out_valid_reg <= 1'b1;
                        first_x_reg   <= '0;
                        second_x_reg  <= '0;
                        last_x_reg    <= '0;
                        count_reg     <= '0;
                        ovf_reg       <= 1'b0;
                        state_reg     <= S_IDLE;
                    end
                default:
                    state_reg <= S_IDLE;
            endcase
        end
    end

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(MAX_POINTS + 1))
        else $error("point count out of range");

    a_clear_after_result: assert property (@(posedge clk) disable iff (!rst_n)
        out_load |=> (count_reg == '0) && !ovf_reg)
        else $error("sequence not cleared after result");

    a_div_done_waiting: assert property (@(posedge clk) disable iff (!rst_n)
        div_rsp.done |-> (state_reg == S_U_WAIT) || (state_reg == S_P_WAIT))
        else $error("divider result with nobody waiting");

    a_series_index: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_P_MUL) |-> (i_reg >= CNT_W'(1)) && (i_reg < count_reg))
        else $error("series index out of range");

endmodule

@@ rtl/backward_difference_interpolator.sv @@
// top level of the newton backward difference interpolator
//
//  channel  handshake             payload               direction
//  in       in_valid / in_ready   in_data  (in_item_t)  point in, query on last
//  out      out_valid / out_ready out_data (out_item_t) one result per last item
//
// a point holds the back end for one difference update per point already held
// an evaluating item adds a division for u and one per series term, then finishes,
// each run on the 49-step bit-serial divider shared by u and every coefficient
// a two-entry queue lets points arrive while the back end is busy
// reset clears the queue, counters and result register; no clearing pass
module backward_difference_interpolator (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  bdi_pkg::in_item_t  in_data,
    output logic               out_valid,
    input  logic               out_ready,
    output bdi_pkg::out_item_t out_data
);
    import bdi_pkg::*;

    logic     q_valid;
    logic     q_ready;
    q_item_t  q_data;
    div_req_t div_req;
    div_rsp_t div_rsp;

    bdi_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .in_data  (in_data),
        .q_valid  (q_valid),
        .q_ready  (q_ready),
        .q_data   (q_data)
    );

    bdi_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    bdi_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_valid   (q_valid),
        .q_ready   (q_ready),
        .q_data    (q_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data),
        .div_req   (div_req),
        .div_rsp   (div_rsp)
    );

endmodule
